// File: design/hsfp_pkg.sv
// Package for the hex sensor frame parser: transaction structs, payload type codes,
// type-table reset values and the hex digit decode function.
// No dependencies.
package hsfp_pkg;

  // Payload type codes held 2 bits per id in the type table
  typedef enum logic [1:0] {
    PT_BOOL  = 2'd0,
    PT_CHAR  = 2'd1,
    PT_FLOAT = 2'd2,
    PT_QUAT  = 2'd3
  } ptype_t;

  localparam int unsigned NUM_TBL_REGS = 8;
  localparam int unsigned TBL_REG_W    = 64;
  localparam int unsigned CFG_IDX_W    = 4;   // one spare bit: writes beyond the table are dropped
  localparam int unsigned TBL_SEL_W    = $clog2(NUM_TBL_REGS);

  typedef logic [TBL_REG_W-1:0] tbl_word_t;

  localparam tbl_word_t TBL_RESET [NUM_TBL_REGS] = '{
    64'd759604205118851072,
    64'd0,
    64'd1319108608,
    64'd0,
    64'd0,
    64'd0,
    64'd0,
    64'd0
  };

  // ASCII ranges of hex digits
  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_9     = 8'h39;
  localparam logic [7:0] ASCII_UP_A  = 8'h41;
  localparam logic [7:0] ASCII_UP_F  = 8'h46;
  localparam logic [7:0] ASCII_LOW_A = 8'h61;
  localparam logic [7:0] ASCII_LOW_F = 8'h66;

  // Last nibble index of a byte and of a 32-bit word
  localparam logic [2:0] LAST_NIB_BYTE = 3'd1;
  localparam logic [2:0] LAST_NIB_WORD = 3'd7;
  localparam logic [1:0] LAST_QUAT_PART = 2'd3;

  typedef struct packed {
    logic [7:0] hex_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  record_id;
    logic [1:0]  payload_type;
    logic [1:0]  component;
    logic [31:0] payload_value;
    logic        frame_error;
    logic        frame_end;
  } out_item_t;

  // Map a character to its hex digit; anything else reads as zero
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= ASCII_0 && c <= ASCII_9) begin
      d = c - ASCII_0;
    end else if (c >= ASCII_UP_A && c <= ASCII_UP_F) begin
      d = c - ASCII_UP_A + 8'd10;
    end else if (c >= ASCII_LOW_A && c <= ASCII_LOW_F) begin
      d = c - ASCII_LOW_A + 8'd10;
    end
    return d[3:0];
  endfunction

endpackage

// File: design/hsfp_type_table.sv
// Payload type table: eight 64-bit configuration registers, 2 bits per record id,
// with a combinational lookup by id. Depends on hsfp_pkg.
module hsfp_type_table
  import hsfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  tbl_word_t            cfg_wdata,
  input  logic [7:0]           lookup_id,
  output ptype_t               lookup_type
);

  tbl_word_t tbl_r [NUM_TBL_REGS];

  logic [TBL_SEL_W-1:0] wr_sel;
  logic                 wr_hit;
  logic [TBL_SEL_W-1:0] rd_sel;
  logic [5:0]           rd_bit;

  assign wr_sel = cfg_index[TBL_SEL_W-1:0];
  assign wr_hit = cfg_we && (cfg_index < CFG_IDX_W'(NUM_TBL_REGS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TBL_REGS; i++) begin
        tbl_r[i] <= TBL_RESET[i];
      end
    end else if (wr_hit) begin
      tbl_r[wr_sel] <= cfg_wdata;
    end
  end

  // Upper id bits pick the register, lower five the 2-bit slot
  assign rd_sel      = lookup_id[7:5];
  assign rd_bit      = {lookup_id[4:0], 1'b0};
  assign lookup_type = ptype_t'(tbl_r[rd_sel][rd_bit +: 2]);

endmodule

// File: design/hsfp_parse.sv
// Record parser: holds the frame parse state and forms at most one result per
// accepted character. Depends on hsfp_pkg.
module hsfp_parse
  import hsfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  in_item_t   in_item,
  output logic [7:0] lookup_id,
  input  ptype_t     lookup_type,
  output logic       res_vld,
  output out_item_t  res_item
);

  logic        in_payload_r, in_payload_nxt;
  logic [7:0]  cur_id_r,     cur_id_nxt;
  ptype_t      cur_type_r,   cur_type_nxt;
  logic [2:0]  nib_cnt_r,    nib_cnt_nxt;
  logic [1:0]  part_r,       part_nxt;
  logic [31:0] acc_r,        acc_nxt;

  logic [31:0] acc_shift;
  logic [2:0]  nib_last;
  logic        have;
  logic        done;
  out_item_t   rec;

  assign acc_shift = {acc_r[27:0], hex_digit(in_item.hex_char)};
  assign lookup_id = acc_shift[7:0];
  assign nib_last  = (cur_type_r == PT_BOOL || cur_type_r == PT_CHAR) ?
                     LAST_NIB_BYTE : LAST_NIB_WORD;

  always_comb begin
    in_payload_nxt = in_payload_r;
    cur_id_nxt     = cur_id_r;
    cur_type_nxt   = cur_type_r;
    nib_cnt_nxt    = nib_cnt_r;
    part_nxt       = part_r;
    acc_nxt        = acc_r;
    have           = 1'b0;
    done           = 1'b0;
    rec            = '0;
    res_vld        = 1'b0;
    res_item       = '0;

    // Record fields of a completed word
    rec.record_id    = cur_id_r;
    rec.payload_type = 2'(cur_type_r);
    rec.component    = (cur_type_r == PT_QUAT) ? part_r : 2'd0;
    case (cur_type_r)
      PT_BOOL: rec.payload_value = {31'd0, |acc_shift[7:0]};
      PT_CHAR: rec.payload_value = {24'd0, acc_shift[7:0]};
      default: rec.payload_value = acc_shift;
    endcase

    if (accept) begin
      if (!in_payload_r) begin
        if (nib_cnt_r == 3'd0) begin
          nib_cnt_nxt = 3'd1;
          acc_nxt     = acc_shift;
        end else begin
          cur_id_nxt     = acc_shift[7:0];
          cur_type_nxt   = lookup_type;
          in_payload_nxt = 1'b1;
          nib_cnt_nxt    = 3'd0;
          part_nxt       = 2'd0;
          acc_nxt        = '0;
        end
      end else if (nib_cnt_r >= nib_last) begin
        have        = 1'b1;
        acc_nxt     = '0;
        nib_cnt_nxt = 3'd0;
        if (cur_type_r == PT_QUAT && part_r < LAST_QUAT_PART) begin
          part_nxt = part_r + 2'd1;
        end else begin
          in_payload_nxt = 1'b0;
          part_nxt       = 2'd0;
          done           = 1'b1;
        end
      end else begin
        nib_cnt_nxt = nib_cnt_r + 3'd1;
        acc_nxt     = acc_shift;
      end

      if (in_item.last_char) begin
        // End of frame: drop all parse state, report record end or error
        in_payload_nxt = 1'b0;
        cur_id_nxt     = '0;
        cur_type_nxt   = PT_BOOL;
        nib_cnt_nxt    = '0;
        part_nxt       = '0;
        acc_nxt        = '0;
        res_vld        = 1'b1;
        if (done) begin
          res_item           = rec;
          res_item.frame_end = 1'b1;
        end else begin
          res_item.frame_error = 1'b1;
          res_item.frame_end   = 1'b1;
        end
      end else if (have) begin
        res_vld  = 1'b1;
        res_item = rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      cur_id_r     <= '0;
      cur_type_r   <= PT_BOOL;
      nib_cnt_r    <= '0;
      part_r       <= '0;
      acc_r        <= '0;
    end else begin
      in_payload_r <= in_payload_nxt;
      cur_id_r     <= cur_id_nxt;
      cur_type_r   <= cur_type_nxt;
      nib_cnt_r    <= nib_cnt_nxt;
      part_r       <= part_nxt;
      acc_r        <= acc_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_part_only_quat: assert property (@(posedge clk) disable iff (!rst_n)
    part_r != 2'd0 |-> in_payload_r && cur_type_r == PT_QUAT)
    else $error("quaternion part index set outside a quaternion payload");

  a_id_nibbles: assert property (@(posedge clk) disable iff (!rst_n)
    !in_payload_r |-> nib_cnt_r <= LAST_NIB_BYTE)
    else $error("nibble count out of range while reading an id");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.last_char |=> !in_payload_r && nib_cnt_r == 3'd0 && acc_r == '0)
    else $error("parse state not cleared after end of frame");
`endif

endmodule

// File: design/hsfp_out_buf.sv
// Result output register with one skid entry, so a new character can be taken
// while a finished result waits. Depends on hsfp_pkg.
module hsfp_out_buf
  import hsfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_vld,
  input  out_item_t res_item,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      out_vld_r,  out_vld_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      skid_vld_r, skid_vld_nxt;
  out_item_t skid_r,     skid_nxt;
  logic      pop;

  assign pop       = out_vld_r && out_ready;
  assign in_ready  = !skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (pop) begin
        out_data_nxt = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (res_vld) begin
      if (!out_vld_r || pop) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = res_item;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_nxt     = res_item;
      end
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    skid_r     <= skid_nxt;
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while output register empty");

  a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && !pop |=> skid_vld_r && $stable(skid_r))
    else $error("skid entry lost or changed before it moved on");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> !res_vld)
    else $error("result produced while skid entry is occupied");
`endif

endmodule

// File: design/hex_sensor_frame_parser.sv
// Top level of the hex sensor frame parser: type table, record parser and result buffer.
// Depends on hsfp_pkg, hsfp_type_table, hsfp_parse and hsfp_out_buf.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): one ASCII character a transaction,
//   last_char marking the final character of a frame. Pairs of hex digits make bytes,
//   high nibble first; a record is an id byte then a payload typed by the table.
//   Result channel (out_valid/out_ready/out_data): one transaction per completed
//   boolean, char or float payload and per quaternion part, or an error transaction
//   when a frame ends inside a record; frame_end flags the last character's result.
//   Configuration port (cfg_we/cfg_index/cfg_wdata): writes one 64-bit type table
//   register a cycle, no wait; indexes beyond the table are dropped. Write only while
//   the parser is idle.
//   A result is registered in the output register, or in the skid entry under a stall.
//   Throughput: one character a cycle while in_ready is high, set by the single parse
//   step between the parse state registers and the output register.
//   Stalls: an output register plus one skid entry absorb a stalled receiver; in_ready
//   drops only once the skid entry holds a result, and rises as soon as it drains.
//   Reset (rst_n low, synchronous): parse state cleared, buffers emptied, type table
//   loaded with its default contents.
module hex_sensor_frame_parser
  import hsfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  tbl_word_t            cfg_wdata
);

  logic       accept;
  logic [7:0] lookup_id;
  ptype_t     lookup_type;
  logic       res_vld;
  out_item_t  res_item;

  // Accept a character whenever the skid entry is free
  assign accept = in_valid && in_ready;

  hsfp_type_table u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .lookup_id   (lookup_id),
    .lookup_type (lookup_type)
  );

  hsfp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_item     (in_data),
    .lookup_id   (lookup_id),
    .lookup_type (lookup_type),
    .res_vld     (res_vld),
    .res_item    (res_item)
  );

  hsfp_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res_item  (res_item),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: test/tb_hex_sensor_frame_parser.sv
// Self-checking testbench for hex_sensor_frame_parser: random hex-text frames under
// random idling on both channels, predicted per character and checked per result.
// Depends on hsfp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_hex_sensor_frame_parser;
  import hsfp_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 8;
  localparam int IDLE_SETTLE      = 4;          // result latency plus skid entry, with margin
  localparam int TIMEOUT_CYCLES   = 1_500_000;
  localparam int MAX_REPORTS      = 10;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PRESSURE_HOLDS   = 2;
  localparam int PRESSURE_FIRST   = 80;         // records checked before the first long hold
  localparam int PRESSURE_SPACING = 220;
  localparam int ID_CHARS         = 2;
  localparam int WORD_CHARS       = 8;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  tbl_word_t            cfg_wdata = '0;

  // Characters waiting to be offered, and records still owed by the parser
  in_item_t   char_queue[$];
  out_item_t  expected_records[$];
  logic [7:0] frame_buf[$];

  // Own copy of the type table and of the parse state
  tbl_word_t   type_tbl [NUM_TBL_REGS];
  logic        parse_in_payload = 1'b0;
  logic [7:0]  parse_id         = '0;
  ptype_t      parse_type       = PT_BOOL;
  logic [2:0]  parse_nibbles    = '0;
  logic [1:0]  parse_part       = '0;
  logic [31:0] parse_acc        = '0;

  int queued_chars    = 0;
  int frames_built    = 0;
  int accepted_chars  = 0;
  int records_checked = 0;
  int error_records   = 0;
  int mismatches      = 0;
  int orphans         = 0;
  int reports         = 0;
  int input_stalls    = 0;
  int table_writes    = 0;
  int send_gap        = 0;
  bit send_steady     = 1'b0;
  int stall_left      = 0;
  bit recv_steady     = 1'b0;
  int pressure_count  = 0;
  int next_pressure   = PRESSURE_FIRST;

  hex_sensor_frame_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Character decode and table lookup
  // ---------------------------------------------------------------------------

  // Hex digit of a character; anything that is not a hex digit reads as zero
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= ASCII_0 && c <= ASCII_9) begin
      v = c - ASCII_0;
    end else if (c >= ASCII_UP_A && c <= ASCII_UP_F) begin
      v = c - ASCII_UP_A + 8'd10;
    end else if (c >= ASCII_LOW_A && c <= ASCII_LOW_F) begin
      v = c - ASCII_LOW_A + 8'd10;
    end
    return v[3:0];
  endfunction

  // Two bits per id: the register picked by the top three id bits, the pair by the rest
  function automatic ptype_t table_type(input logic [7:0] id);
    tbl_word_t row;
    row = type_tbl[id[7:5]];
    return ptype_t'(row[{id[4:0], 1'b0} +: 2]);
  endfunction

  // ---------------------------------------------------------------------------
  // Record prediction: advance the parse state by one accepted character and
  // queue the record it completes, if any
  // ---------------------------------------------------------------------------
  task automatic decode_char(input in_item_t item);
    logic [2:0] last_nib;
    logic       done;
    logic       have;
    out_item_t  rec;
    rec  = '0;
    have = 1'b0;
    done = 1'b0;
    parse_acc = {parse_acc[27:0], nibble_of(item.hex_char)};

    if (!parse_in_payload) begin
      // Id byte: the second nibble latches the id and its payload type
      if (parse_nibbles == 3'd0) begin
        parse_nibbles = 3'd1;
      end else begin
        parse_id         = parse_acc[7:0];
        parse_type       = table_type(parse_acc[7:0]);
        parse_in_payload = 1'b1;
        parse_nibbles    = 3'd0;
        parse_part       = 2'd0;
        parse_acc        = '0;
      end
    end else begin
      last_nib = (parse_type == PT_BOOL || parse_type == PT_CHAR) ? LAST_NIB_BYTE
                                                                  : LAST_NIB_WORD;
      if (parse_nibbles >= last_nib) begin
        have               = 1'b1;
        rec.record_id      = parse_id;
        rec.payload_type   = parse_type;
        rec.component      = (parse_type == PT_QUAT) ? parse_part : 2'd0;
        case (parse_type)
          PT_BOOL: begin
            rec.payload_value = {31'd0, parse_acc[7:0] != 8'd0};
          end
          PT_CHAR: begin
            rec.payload_value = {24'd0, parse_acc[7:0]};
          end
          default: begin
            rec.payload_value = parse_acc;
          end
        endcase
        parse_acc     = '0;
        parse_nibbles = 3'd0;
        if (parse_type == PT_QUAT && parse_part < LAST_QUAT_PART) begin
          parse_part = parse_part + 2'd1;
        end else begin
          parse_in_payload = 1'b0;
          parse_part       = 2'd0;
          done             = 1'b1;
        end
      end else begin
        parse_nibbles = parse_nibbles + 3'd1;
      end
    end

    if (item.last_char) begin
      // Frame end: the completed record closes it, anything else is an error
      parse_in_payload = 1'b0;
      parse_id         = '0;
      parse_type       = PT_BOOL;
      parse_nibbles    = '0;
      parse_part       = '0;
      parse_acc        = '0;
      if (!done) begin
        rec = '0;
        rec.frame_error = 1'b1;
      end
      rec.frame_end = 1'b1;
      expected_records.push_back(rec);
    end else if (have) begin
      expected_records.push_back(rec);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Text for one nibble: either letter case, and a zero sometimes as a non-hex character
  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    logic [7:0] c;
    if (n == 4'd0 && $urandom_range(0, 5) == 0) begin
      do begin
        c = 8'($urandom_range(0, 255));
      end while (nibble_of(c) != 4'd0 || c == ASCII_0);
    end else if (n < 4'd10) begin
      c = ASCII_0 + 8'(n);
    end else if ($urandom_range(0, 1) == 1) begin
      c = ASCII_UP_A + 8'(n) - 8'd10;
    end else begin
      c = ASCII_LOW_A + 8'(n) - 8'd10;
    end
    return c;
  endfunction

  // Byte values leaning towards the edges of the range
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] id_with_type(input ptype_t t);
    logic [7:0] hit;
    hit = 8'd0;
    for (int id = 255; id >= 0; id--) begin
      if (table_type(8'(id)) == t) hit = 8'(id);
    end
    return hit;
  endfunction

  task automatic append_byte(input logic [7:0] b);
    frame_buf.push_back(nibble_char(b[7:4]));
    frame_buf.push_back(nibble_char(b[3:0]));
  endtask

  // Id byte, then as many payload bytes as the current table gives for that id
  task automatic append_record(input logic [7:0] id);
    int nbytes;
    append_byte(id);
    case (table_type(id))
      PT_FLOAT: nbytes = 4;
      PT_QUAT:  nbytes = 16;
      default:  nbytes = 1;
    endcase
    repeat (nbytes) append_byte(pick_byte());
  endtask

  // Queue the first keep characters of the frame, last_char on the final one
  task automatic flush_frame(input int keep);
    for (int i = 0; i < keep; i++) begin
      char_queue.push_back('{hex_char: frame_buf[i], last_char: (i == keep - 1)});
    end
    queued_chars += keep;
    frames_built++;
    frame_buf.delete();
  endtask

  task automatic directed_frames();
    // Zero boolean, all-ones char and a float with both end bits set, in one frame
    append_byte(id_with_type(PT_BOOL));
    append_byte(8'h00);
    append_byte(id_with_type(PT_CHAR));
    append_byte(8'hFF);
    append_byte(id_with_type(PT_FLOAT));
    append_byte(8'h80);
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(8'h01);
    flush_frame(frame_buf.size());
    // Frame of one non-hex character: ends inside the id
    frame_buf.push_back("G");
    flush_frame(1);
    // Quaternion cut after its first payload digit
    append_byte(id_with_type(PT_QUAT));
    frame_buf.push_back("7");
    flush_frame(frame_buf.size());
    // Id spelt with high non-hex characters, which read as zeros
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'h80);
    frame_buf.push_back("0");
    frame_buf.push_back("1");
    flush_frame(frame_buf.size());
  endtask

  // Mostly well-formed frames, some cut inside their last record, some plain noise
  task automatic random_phase(input int budget);
    int         start_count;
    int         rec_start;
    int         cut;
    int         kind;
    logic [7:0] id;
    start_count = queued_chars;
    while (queued_chars - start_count < budget) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        repeat ($urandom_range(1, 4)) begin
          id = ($urandom_range(0, 9) == 0) ? 8'h00 :
               ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
          append_record(id);
        end
        flush_frame(frame_buf.size());
      end else if (kind < 9) begin
        repeat ($urandom_range(0, 2)) append_record(8'($urandom_range(0, 255)));
        rec_start = frame_buf.size();
        id        = 8'($urandom_range(0, 255));
        append_record(id);
        if (table_type(id) == PT_QUAT && $urandom_range(0, 1) == 1) begin
          // end exactly on a quaternion part boundary
          cut = rec_start + ID_CHARS + WORD_CHARS * $urandom_range(1, 3);
        end else begin
          cut = $urandom_range(rec_start + 1, frame_buf.size() - 1);
        end
        flush_frame(cut);
      end else begin
        repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom_range(0, 255)));
        flush_frame(frame_buf.size());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Configuration writes, only with the parser idle
  // ---------------------------------------------------------------------------
  task automatic write_table_reg(input logic [CFG_IDX_W-1:0] idx, input tbl_word_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < NUM_TBL_REGS) type_tbl[idx[TBL_SEL_W-1:0]] = val;
    table_writes++;
  endtask

  // Fill every register, then hit one spare index that the parser must drop
  task automatic program_table(input tbl_word_t fill, input bit scramble);
    for (int i = 0; i < NUM_TBL_REGS; i++) begin
      write_table_reg(CFG_IDX_W'(i), scramble ? {$urandom, $urandom} : fill);
    end
    write_table_reg(CFG_IDX_W'($urandom_range(NUM_TBL_REGS, (1 << CFG_IDX_W) - 1)),
                    {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued character is taken and every record has come back
  task automatic wait_idle();
    while (char_queue.size() != 0 || in_valid || expected_records.size() != 0) begin
      @(posedge clk);
    end
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued characters with random gaps; predict each transaction
  // at the edge that accepts it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_ready) input_stalls++;
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          decode_char(in_data);
          accepted_chars++;
        end
        if (send_gap > 0 || char_queue.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          in_data  <= char_queue.pop_front();
          in_valid <= 1'b1;
          // switch between back-to-back stretches and gappy ones now and then
          if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
          send_gap = send_steady ? 0 : pick_gap();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and receiver: check each result transaction against the oldest
  // expected record, and drive out_ready with random stalls plus long holds
  // that back the parser up until it drops in_ready
  // ---------------------------------------------------------------------------
  task automatic check_record(input out_item_t got);
    out_item_t want;
    if (expected_records.size() == 0) begin
      orphans++;
      if (reports < MAX_REPORTS) begin
        $display("[%0t] unexpected record: id %02h type %0d comp %0d value %08h err %b end %b",
                 $time, got.record_id, got.payload_type, got.component,
                 got.payload_value, got.frame_error, got.frame_end);
      end
      reports++;
    end else begin
      want = expected_records.pop_front();
      records_checked++;
      if (want.frame_error) error_records++;
      if (got.record_id !== want.record_id || got.payload_type !== want.payload_type ||
          got.component !== want.component || got.payload_value !== want.payload_value ||
          got.frame_error !== want.frame_error || got.frame_end !== want.frame_end) begin
        mismatches++;
        if (reports < MAX_REPORTS) begin
          $display("[%0t] record mismatch", $time);
          $display("  expected id %02h type %0d comp %0d value %08h err %b end %b",
                   want.record_id, want.payload_type, want.component,
                   want.payload_value, want.frame_error, want.frame_end);
          $display("  actual   id %02h type %0d comp %0d value %08h err %b end %b",
                   got.record_id, got.payload_type, got.component,
                   got.payload_value, got.frame_error, got.frame_end);
        end
        reports++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) check_record(out_data);
      // long hold: the sender keeps offering, so skid and output register fill up
      if (pressure_count < PRESSURE_HOLDS && records_checked >= next_pressure) begin
        stall_left = LONG_HOLD_CYCLES;
        pressure_count++;
        next_pressure += PRESSURE_SPACING;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) == 0) recv_steady = !recv_steady;
        if (!recv_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed frames on the reset table, then random phases
  // under a range of table settings, drained between settings
  // ---------------------------------------------------------------------------
  initial begin
    foreach (type_tbl[i]) type_tbl[i] = TBL_RESET[i];
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    directed_frames();
    random_phase(300);
    wait_idle();

    program_table('0, 1'b0);                 // every id boolean
    random_phase(200);
    wait_idle();

    program_table('1, 1'b0);                 // every id quaternion
    random_phase(300);
    wait_idle();

    program_table({32{2'(PT_CHAR)}}, 1'b0);
    random_phase(200);
    wait_idle();

    program_table({32{2'(PT_FLOAT)}}, 1'b0);
    random_phase(250);
    wait_idle();

    program_table('0, 1'b1);
    random_phase(300);
    wait_idle();

    program_table('0, 1'b1);
    random_phase(300);
    wait_idle();

    if (expected_records.size() != 0) begin
      $display("%0d expected records never arrived", expected_records.size());
    end
    $display("Run covered %0d characters in %0d frames over %0d table writes.",
             accepted_chars, frames_built, table_writes);
    $display("Checked %0d records (%0d frame errors); input held off for %0d cycles.",
             records_checked, error_records, input_stalls);
    if (mismatches == 0 && orphans == 0 && expected_records.size() == 0) begin
      $display("hex_sensor_frame_parser verification clean");
    end else begin
      $display("hex_sensor_frame_parser verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Timed out with %0d characters queued and %0d records outstanding",
             char_queue.size(), expected_records.size());
    $display("hex_sensor_frame_parser verification failed");
    $finish;
  end

endmodule
